>>> src/mprgb_pkg.sv
// ----------------------------------------------------------------------------
// mprgb_pkg
// Shared types, register indexes and constants of the masked pixel to RGB888
// converter.
// ----------------------------------------------------------------------------
package mprgb_pkg;

    // pipeline depth of one color lane, output register included
    localparam int NUM_STAGES = 5;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_MASK   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_MASK = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_MASK  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_BYTE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_FIRST  = 3'd4;

    // reset values of the registers
    localparam logic [31:0] RED_MASK_RESET   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RESET = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RESET  = 32'h0000_00FF;

    // fixed point of the reciprocal used to scale narrow fields
    localparam int RECIP_SHIFT = 16;

    // per-stage load enables, driven by the top level pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    // floor(2^16 / (2^w - 1)) for field widths one to seven
    function automatic logic [16:0] narrow_recip(input logic [2:0] w);
        logic [16:0] r;
        case (w)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd21845;
            3'd3:    r = 17'd9362;
            3'd4:    r = 17'd4369;
            3'd5:    r = 17'd2114;
            3'd6:    r = 17'd1040;
            3'd7:    r = 17'd516;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // largest value of a field of width w
    function automatic logic [6:0] field_top(input logic [2:0] w);
        logic [7:0] t;
        t = (8'd1 << w) - 8'd1;
        return t[6:0];
    endfunction

    // binary index of the single set bit of a one-hot word
    function automatic logic [4:0] onehot_index(input logic [31:0] oh);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (oh[i])
            begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> src/mprgb_lane.sv
// ----------------------------------------------------------------------------
// mprgb_lane
// One color channel: finds the lowest run of ones in the mask, extracts the
// field from the pixel word and scales it to eight bits, over five stages.
// ----------------------------------------------------------------------------
module mprgb_lane (
    input  logic                 clk,
    input  mprgb_pkg::pipe_ctrl_t ctrl,
    input  logic [31:0]          word,
    input  logic [31:0]          mask,
    output logic [7:0]           level
);

    // stage 1: pixel word and the lowest run of the mask
    logic [31:0] word1_reg, run1_reg;
    logic [31:0] low_bit, run_next;

    // stage 2: field bits, run ends
    logic [31:0] fld2_reg;
    logic [4:0]  lsb2_reg, msb2_reg;
    logic        ne2_reg;
    logic [31:0] lo_oh, hi_oh;

    // stage 3: wide result, or dividend of the narrow scaling
    logic        wide3_reg, ne3_reg;
    logic [7:0]  wlev3_reg;
    logic [14:0] x3_reg;
    logic [2:0]  w3_reg;
    logic [4:0]  span;
    logic [31:0] sh_hi, sh_lo;
    logic [6:0]  v_next, top3;
    logic [2:0]  w_next;
    logic [14:0] x_next;

    // stage 4: quotient estimate
    logic        wide4_reg, ne4_reg;
    logic [7:0]  wlev4_reg, qest4_reg;
    logic [14:0] x4_reg;
    logic [2:0]  w4_reg;
    logic [31:0] recip_prod;

    // stage 5: corrected quotient and final level
    logic [7:0]  level5_reg, level_next, q_next;
    logic [6:0]  top5;
    logic [14:0] back_prod, rem;

    // lowest run: the add clears the run and carries past it
    assign low_bit  = mask & (~mask + 32'd1);
    assign run_next = mask & ~(mask + low_bit);

    // ends of the run as one-hot words
    assign lo_oh = run1_reg & (~run1_reg + 32'd1);
    assign hi_oh = run1_reg & ~(run1_reg >> 1);

    // field alignment for both cases
    assign span   = msb2_reg - lsb2_reg;
    assign sh_hi  = fld2_reg >> (msb2_reg - 5'd7);
    assign sh_lo  = fld2_reg >> lsb2_reg;
    assign v_next = sh_lo[6:0];
    assign w_next = span[2:0] + 3'd1;
    assign top3   = mprgb_pkg::field_top(w_next);
    assign x_next = ({v_next, 8'b0} - {8'b0, v_next}) + {9'b0, top3[6:1]};

    // quotient estimate by reciprocal, low by at most one
    assign recip_prod = {17'b0, x3_reg} * {15'b0, mprgb_pkg::narrow_recip(w3_reg)};

    // correction step
    assign top5      = mprgb_pkg::field_top(w4_reg);
    assign back_prod = {7'b0, qest4_reg} * {8'b0, top5};
    assign rem       = x4_reg - back_prod;
    assign q_next    = (rem >= {8'b0, top5}) ? qest4_reg + 8'd1 : qest4_reg;

    // level select
    always_comb
    begin
        if (!ne4_reg)
        begin
            level_next = 8'd0;
        end
        else if (wide4_reg)
        begin
            level_next = wlev4_reg;
        end
        else
        begin
            level_next = q_next;
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            word1_reg <= word;
            run1_reg  <= run_next;
        end
        if (ctrl.load[1])
        begin
            fld2_reg <= word1_reg & run1_reg;
            lsb2_reg <= mprgb_pkg::onehot_index(lo_oh);
            msb2_reg <= mprgb_pkg::onehot_index(hi_oh);
            ne2_reg  <= |run1_reg;
        end
        if (ctrl.load[2])
        begin
            wide3_reg <= (span >= 5'd7);
            ne3_reg   <= ne2_reg;
            wlev3_reg <= sh_hi[7:0];
            x3_reg    <= x_next;
            w3_reg    <= w_next;
        end
        if (ctrl.load[3])
        begin
            wide4_reg <= wide3_reg;
            ne4_reg   <= ne3_reg;
            wlev4_reg <= wlev3_reg;
            qest4_reg <= recip_prod[mprgb_pkg::RECIP_SHIFT+7:mprgb_pkg::RECIP_SHIFT];
            x4_reg    <= x3_reg;
            w4_reg    <= w3_reg;
        end
        if (ctrl.load[4])
        begin
            level5_reg <= level_next;
        end
    end

    assign level = level5_reg;

endmodule

>>> src/masked_pixel_to_rgb888_top.sv
// ----------------------------------------------------------------------------
// masked_pixel_to_rgb888_top
// Converts one 24- or 32-bit truecolor pixel to 8-bit red, green and blue
// using a programmable bit mask per channel.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock while the output is not stalled: three
// identical five-stage lanes (field search, run ends and extraction, field
// alignment, reciprocal multiply, correction into the output register) run side
// by side. A stall at the output backs the pipeline up one stage at a time
// and in_stall rises only when all five stages hold an item. Masks and byte
// order are sampled when an item is accepted, so a register write is seen by
// the first item accepted after it.
module masked_pixel_to_rgb888_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [mprgb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    // input items
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [31:0]                      pixel_bytes,
    // result items
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       red_level,
    output logic [7:0]                       green_level,
    output logic [7:0]                       blue_level
);

    localparam int NS = mprgb_pkg::NUM_STAGES;

    logic [31:0] red_field_reg, green_field_reg, blue_field_reg;
    logic        four_byte_reg, low_first_reg;
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] adv;
    logic [31:0] word_next;
    mprgb_pkg::pipe_ctrl_t ctrl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_field_reg   <= mprgb_pkg::RED_MASK_RESET;
            green_field_reg <= mprgb_pkg::GREEN_MASK_RESET;
            blue_field_reg  <= mprgb_pkg::BLUE_MASK_RESET;
            four_byte_reg   <= 1'b1;
            low_first_reg   <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mprgb_pkg::CFG_RED_MASK:   red_field_reg   <= cfg_data;
                mprgb_pkg::CFG_GREEN_MASK: green_field_reg <= cfg_data;
                mprgb_pkg::CFG_BLUE_MASK:  blue_field_reg  <= cfg_data;
                mprgb_pkg::CFG_FOUR_BYTE:  four_byte_reg   <= cfg_data[0];
                mprgb_pkg::CFG_LOW_FIRST:  low_first_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // byte assembly of the pixel word
    always_comb
    begin
        case ({four_byte_reg, low_first_reg})
            2'b11:   word_next = pixel_bytes;
            2'b10:   word_next = {pixel_bytes[7:0], pixel_bytes[15:8],
                                  pixel_bytes[23:16], pixel_bytes[31:24]};
            2'b01:   word_next = {8'b0, pixel_bytes[23:0]};
            default: word_next = {8'b0, pixel_bytes[7:0], pixel_bytes[15:8],
                                  pixel_bytes[23:16]};
        endcase
    end

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign ctrl.load = adv;
    assign in_stall  = !adv[0];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[NS-1];

    // color lanes
    mprgb_lane u_red (
        .clk   (clk),
        .ctrl  (ctrl),
        .word  (word_next),
        .mask  (red_field_reg),
        .level (red_level)
    );

    mprgb_lane u_green (
        .clk   (clk),
        .ctrl  (ctrl),
        .word  (word_next),
        .mask  (green_field_reg),
        .level (green_level)
    );

    mprgb_lane u_blue (
        .clk   (clk),
        .ctrl  (ctrl),
        .word  (word_next),
        .mask  (blue_field_reg),
        .level (blue_level)
    );

endmodule

>>> src/mprgb_checker.sv
// ----------------------------------------------------------------------------
// mprgb_checker
// Port-level checks of the masked pixel to RGB888 converter, bound to the
// top level.
// ----------------------------------------------------------------------------
module mprgb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_wr_en,
    input logic [mprgb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [31:0]                      cfg_data,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic [31:0]                      pixel_bytes,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [7:0]                       red_level,
    input logic [7:0]                       green_level,
    input logic [7:0]                       blue_level
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_level)
            && $stable(green_level) && $stable(blue_level))
    else $error("stalled result item changed");

    // the input backs up only behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

    // an accepted item comes out when the output stays free behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
            ##1 !out_stall |=> out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind masked_pixel_to_rgb888_top mprgb_checker u_mprgb_checker (.*);
